/* rtl/slab_slot_allocator_top_macros.svh */
// assertion macros used by the checker file
// both expect a clock named clk and an active-low reset named arst_n in scope
`ifndef SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SSA_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("slab allocator assertion failed");

// antecedent in one cycle, consequent in the next
`define SSA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slab allocator assertion failed");

`endif

/* rtl/ssa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OOM       = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam int CFG_DATA_W = 13;
	localparam logic CFG_OBJECT_SIZE    = 1'b0;
	localparam logic CFG_SLOTS_PER_SLAB = 1'b1;

	localparam logic [12:0] OBJECT_SIZE_RST    = 13'd64;
	localparam logic [6:0]  SLOTS_PER_SLAB_RST = 7'd64;

	typedef struct packed {
		logic       action;
		logic [2:0] free_slab;
		logic [5:0] free_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  slab_index;
		logic [5:0]  slot_index;
		logic [11:0] byte_offset;
		logic        slab_opened;
		logic [6:0]  used_in_slab;
	} rsp_t;

	// classified request as queued between front and back
	typedef struct packed {
		logic       is_free;
		logic       bad;
		logic [2:0] slab;
		logic [5:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [12:0] object_size;
		logic [6:0]  slot_limit;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/ssa_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssa_front #(
	parameter int MAX_SLABS = 8,
	parameter int SLOTS_MAX = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [ssa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire ssa_pkg::req_t                 req,
	output logic                               cmd_valid,
	input  wire logic                          cmd_ready,
	output ssa_pkg::cmd_t                      cmd,
	output ssa_pkg::cfg_t                      cfg
);
	import ssa_pkg::*;

	logic [12:0] object_size_q;
	logic [6:0]  slots_per_slab_q;
	logic [6:0]  lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_size_q    <= OBJECT_SIZE_RST;
			slots_per_slab_q <= SLOTS_PER_SLAB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OBJECT_SIZE:    object_size_q    <= cfg_data;
				CFG_SLOTS_PER_SLAB: slots_per_slab_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// slot limit clamped to one at the bottom and the slab width at the top
	always_comb begin
		lim = slots_per_slab_q;
		if (lim == 7'd0) begin
			lim = 7'd1;
		end
		if (lim > 7'(SLOTS_MAX)) begin
			lim = 7'(SLOTS_MAX);
		end
	end

	assign cfg.object_size = object_size_q;
	assign cfg.slot_limit  = lim;

	assign cmd_valid   = req_valid;
	assign req_ready   = cmd_ready;
	assign cmd.is_free = (req.action == ACT_FREE);
	assign cmd.bad     = (int'(req.free_slab) >= MAX_SLABS) || ({1'b0, req.free_slot} >= lim);
	assign cmd.slab    = req.free_slab;
	assign cmd.slot    = req.free_slot;

endmodule

`default_nettype wire

/* rtl/ssa_cmd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssa_cmd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ssa_pkg::cmd_t in_cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ssa_pkg::cmd_t      out_cmd
);
	import ssa_pkg::*;

	// two entries
	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/ssa_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssa_back #(
	parameter int MAX_SLABS  = 8,
	parameter int SLOTS_MAX  = 64,
	parameter int SLAB_BYTES = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ssa_pkg::cfg_t cfg,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire ssa_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output ssa_pkg::rsp_t      rsp
);
	import ssa_pkg::*;

	localparam int SLAB_W  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
	localparam int ACT_W   = $clog2(MAX_SLABS + 1);
	localparam int SLOT_W  = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
	localparam int CAP_INT = (SLAB_BYTES - 1 < 4095) ? SLAB_BYTES - 1 : 4095;
	localparam logic [18:0] OFF_CAP = 19'(CAP_INT);

	typedef enum logic {S_PICK, S_COMMIT} state_t;
	typedef enum logic [2:0] {K_ALLOC, K_OPEN, K_FREE, K_OOM, K_MISS} kind_t;

	// slab state
	logic [SLOTS_MAX-1:0] map_q [MAX_SLABS];
	logic [6:0]           used_q [MAX_SLABS];
	logic [ACT_W-1:0]     active_q;

	state_t state_q;
	rsp_t   rsp_q;
	logic   rsp_valid_q;

	// pick stage
	logic [SLOTS_MAX-1:0] mask;
	logic [MAX_SLABS-1:0] avail;
	logic                 any;
	logic [SLAB_W-1:0]    first;
	logic [SLAB_W-1:0]    sel;
	logic [SLOTS_MAX-1:0] row;
	kind_t                kind_d;
	logic                 pick_fire;

	kind_t                kind_s1;
	logic [SLAB_W-1:0]    sel_s1;
	logic [SLOTS_MAX-1:0] row_s1;
	logic [SLOTS_MAX-1:0] freebits_s1;
	logic [6:0]           cnt_s1;
	logic [2:0]           slab_echo_s1;
	logic [5:0]           slot_echo_s1;

	// commit stage
	logic [SLOT_W-1:0]    slot_enc;
	logic [SLOT_W-1:0]    slot_c;
	logic [SLOTS_MAX-1:0] onehot;
	logic [SLOTS_MAX-1:0] row_n;
	logic [6:0]           cnt_n;
	logic                 wr_en;
	logic [5:0]           slot_out;
	logic [18:0]          prod;
	logic [11:0]          offset;
	rsp_t                 rsp_d;
	logic                 commit_fire;

	always_comb begin
		for (int i = 0; i < SLOTS_MAX; i++) begin
			mask[i] = (7'(i) < cfg.slot_limit);
		end
	end

	always_comb begin
		for (int s = 0; s < MAX_SLABS; s++) begin
			avail[s] = (ACT_W'(s) < active_q) && (|(~map_q[s] & mask));
		end
	end

	// lowest active slab with a free slot below the limit
	always_comb begin
		any   = 1'b0;
		first = '0;
		for (int s = MAX_SLABS - 1; s >= 0; s--) begin
			if (avail[s]) begin
				any   = 1'b1;
				first = SLAB_W'(s);
			end
		end
	end

	always_comb begin
		sel    = first;
		kind_d = K_OOM;
		if (cmd.is_free) begin
			sel = SLAB_W'(cmd.slab);
		end else if (!any && (active_q < ACT_W'(MAX_SLABS))) begin
			sel = SLAB_W'(active_q);
		end
		row = map_q[sel];
		if (cmd.is_free) begin
			if (cmd.bad || !(ACT_W'(cmd.slab) < active_q) || !row[SLOT_W'(cmd.slot)]) begin
				kind_d = K_MISS;
			end else begin
				kind_d = K_FREE;
			end
		end else if (any) begin
			kind_d = K_ALLOC;
		end else if (active_q < ACT_W'(MAX_SLABS)) begin
			kind_d = K_OPEN;
		end else begin
			kind_d = K_OOM;
		end
	end

	assign cmd_ready   = (state_q == S_PICK);
	assign pick_fire   = cmd_valid && cmd_ready;
	assign commit_fire = (state_q == S_COMMIT) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk) begin
		if (pick_fire) begin
			kind_s1      <= kind_d;
			sel_s1       <= sel;
			row_s1       <= row;
			freebits_s1  <= ~row & mask;
			cnt_s1       <= used_q[sel];
			slab_echo_s1 <= cmd.slab;
			slot_echo_s1 <= cmd.slot;
		end
	end

	always_comb begin
		slot_enc = '0;
		for (int i = SLOTS_MAX - 1; i >= 0; i--) begin
			if (freebits_s1[i]) begin
				slot_enc = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		case (kind_s1)
			K_ALLOC: slot_c = slot_enc;
			K_FREE:  slot_c = SLOT_W'(slot_echo_s1);
			default: slot_c = '0;
		endcase
		for (int i = 0; i < SLOTS_MAX; i++) begin
			onehot[i] = (SLOT_W'(i) == slot_c);
		end
		row_n = row_s1;
		cnt_n = cnt_s1;
		wr_en = 1'b0;
		case (kind_s1)
			K_ALLOC, K_OPEN: begin
				row_n = row_s1 | onehot;
				cnt_n = cnt_s1 + 7'd1;
				wr_en = 1'b1;
			end
			K_FREE: begin
				row_n = row_s1 & ~onehot;
				cnt_n = cnt_s1 - 7'd1;
				wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	assign slot_out = 6'(slot_c);
	assign prod     = {13'd0, slot_out} * {6'd0, cfg.object_size};
	assign offset   = (prod > OFF_CAP) ? OFF_CAP[11:0] : prod[11:0];

	always_comb begin
		rsp_d = '0;
		case (kind_s1)
			K_ALLOC, K_OPEN, K_FREE: begin
				rsp_d.status       = ST_OK;
				rsp_d.slab_index   = 3'(sel_s1);
				rsp_d.slot_index   = slot_out;
				rsp_d.byte_offset  = offset;
				rsp_d.slab_opened  = (kind_s1 == K_OPEN);
				rsp_d.used_in_slab = cnt_n;
			end
			K_MISS: begin
				rsp_d.status     = ST_NOT_FOUND;
				rsp_d.slab_index = slab_echo_s1;
				rsp_d.slot_index = slot_echo_s1;
			end
			default: rsp_d.status = ST_OOM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLABS; s++) begin
				map_q[s]  <= '0;
				used_q[s] <= 7'd0;
			end
			active_q <= ACT_W'(1);
		end else if (commit_fire) begin
			if (wr_en) begin
				map_q[sel_s1]  <= row_n;
				used_q[sel_s1] <= cnt_n;
			end
			if (kind_s1 == K_OPEN) begin
				active_q <= active_q + ACT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_PICK;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			case (state_q)
				S_PICK: begin
					if (cmd_valid) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit_fire) begin
						state_q <= S_PICK;
					end
				end
				default: state_q <= S_PICK;
			endcase
			// a new response may replace one taken in the same cycle
			if (commit_fire) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* rtl/slab_slot_allocator_top.sv */
// path: a request is written into the queue, then registered by the pick step and then as the
// response, which becomes valid once the response side is free; the back end takes no new
// request until the pick and commit steps of the used-map read-modify-write are done
// a two-entry queue lets requests be taken while a response waits
// reset (async, active low): all slots free, slab 0 active, object size 64, 64 slots per slab
`timescale 1ns / 1ps
`default_nettype none

module slab_slot_allocator_top #(
	parameter int MAX_SLABS  = 8,
	parameter int SLOTS_MAX  = 64,
	parameter int SLAB_BYTES = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [ssa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire ssa_pkg::req_t                 req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output ssa_pkg::rsp_t                      rsp
);
	import ssa_pkg::*;

	cmd_t front_cmd;
	cmd_t back_cmd;
	cfg_t cfg;
	logic front_valid;
	logic front_ready;
	logic back_valid;
	logic back_ready;

	ssa_front #(
		.MAX_SLABS(MAX_SLABS),
		.SLOTS_MAX(SLOTS_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd      (front_cmd),
		.cfg      (cfg)
	);

	ssa_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_cmd   (front_cmd),
		.out_valid(back_valid),
		.out_ready(back_ready),
		.out_cmd  (back_cmd)
	);

	ssa_back #(
		.MAX_SLABS (MAX_SLABS),
		.SLOTS_MAX (SLOTS_MAX),
		.SLAB_BYTES(SLAB_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.cmd      (back_cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

/* rtl/ssa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "slab_slot_allocator_top_macros.svh"

module ssa_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire ssa_pkg::rsp_t rsp
);
	import ssa_pkg::*;

	// out of memory carries nothing but its status
	`SSA_ASSERT(a_oom_clean, rsp_valid && (rsp.status == ST_OOM) |-> (rsp.slab_index == 3'd0) && (rsp.slot_index == 6'd0) && (rsp.byte_offset == 12'd0) && !rsp.slab_opened && (rsp.used_in_slab == 7'd0))

	// a rejected free leaves offset, open flag and count at zero
	`SSA_ASSERT(a_miss_clean, rsp_valid && (rsp.status == ST_NOT_FOUND) |-> (rsp.byte_offset == 12'd0) && !rsp.slab_opened && (rsp.used_in_slab == 7'd0))

	// a freshly opened slab hands out slot 0 and holds exactly one object
	`SSA_ASSERT(a_open_first, rsp_valid && rsp.slab_opened |-> (rsp.status == ST_OK) && (rsp.slot_index == 6'd0) && (rsp.byte_offset == 12'd0) && (rsp.used_in_slab == 7'd1))

	`SSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind slab_slot_allocator_top ssa_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire
